FILE: rtl/c8x_pkg.sv
// ----------------------------------------------------------------------------
// c8x_pkg: shared types and constants of the CHIP-8 subset execute unit
// Opcode fields, status codes, and the write-port structs of the register
// file and the return stack.
// ----------------------------------------------------------------------------
package c8x_pkg;

    localparam int unsigned STACK_DEPTH = 16;
    localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int unsigned SA_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int unsigned PC_W   = 12;
    localparam int unsigned REG_W  = 8;
    localparam int unsigned IDX_W  = 4;
    localparam int unsigned NUM_REGS = 16;

    localparam logic [IDX_W-1:0] FLAG_IDX = 4'hF;

    // opcode groups (top nibble)
    localparam logic [3:0] GRP_SYS    = 4'h0;
    localparam logic [3:0] GRP_JUMP   = 4'h1;
    localparam logic [3:0] GRP_CALL   = 4'h2;
    localparam logic [3:0] GRP_SE_IMM = 4'h3;
    localparam logic [3:0] GRP_SE_REG = 4'h5;
    localparam logic [3:0] GRP_ALU    = 4'h8;

    // full words and sub-codes
    localparam logic [15:0] OP_CLS   = 16'h00E0;
    localparam logic [15:0] OP_RET   = 16'h00EE;
    localparam logic [3:0]  ALU_ADD  = 4'h4;
    localparam logic [3:0]  SE_REG_N = 4'h0;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNDERFLOW   = 2'd1,
        ST_OVERFLOW    = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } c8x_status_t;

    typedef struct packed {
        logic             en;       // write V0..VE
        logic [IDX_W-1:0] idx;
        logic [REG_W-1:0] val;
        logic             vf_en;    // write VF
        logic [REG_W-1:0] vf_val;
    } c8x_rf_wr_t;

    typedef struct packed {
        logic            en;
        logic [SA_W-1:0] addr;
        logic [PC_W-1:0] data;
    } c8x_stk_wr_t;

endpackage

FILE: rtl/chip8_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// chip8_subset_execute_unit: CHIP-8 subset instruction execute unit
// Executes 00E0, 00EE, 1NNN, 2NNN, 3XKK, 5XY0 and 8XY4 against a register
// file and a return stack held in synchronous memories.
//
//   channel   signals                         direction  transfer when
//   --------  ------------------------------  ---------  ---------------------
//   input     in_valid/in_stall, instruction   in         in_valid & !in_stall
//   output    out_valid/out_stall, 8 fields    out        out_valid & !out_stall
//   config    cfg_write_en, cfg_write_data     in         cfg_write_en
//
// One instruction per cycle sustained while the output is not stalled. The
// register file and stack are read at the input transfer edge, which loads
// the execute stage; the execute stage then computes and, when it retires,
// loads the output register, which holds the result until it transfers.
// Reset loads the program counter with 512 and empties the stack; VF is
// cleared and V0..VE read as zero until written. A stalled output holds the
// execute stage, which in turn stalls the input.
// ----------------------------------------------------------------------------
module chip8_subset_execute_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] instruction,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] next_pc,
    output logic [1:0]  status,
    output logic        clear_display,
    output logic        skipped,
    output logic        wrote_register,
    output logic [3:0]  write_index,
    output logic [7:0]  write_value,
    output logic        carry,

    input  logic        cfg_write_en,
    input  logic [11:0] cfg_write_data
);
    import c8x_pkg::*;

    localparam logic [PC_W-1:0] PC_RESET = 12'd512;
    localparam logic [SP_W-1:0] SP_FULL  = SP_W'(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_ONE   = SP_W'(1);
    localparam logic [PC_W-1:0] PC_STEP  = PC_W'(2);

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic        ex_valid_reg;
    logic        out_valid_reg;
    logic [15:0] ex_instr_reg;
    logic        ex_adv;      // execute stage may move into the output register
    logic        in_xfer;
    logic        commit;      // execute stage retires this cycle

    assign ex_adv   = !out_valid_reg || !out_stall;
    assign in_stall = ex_valid_reg && !ex_adv;
    assign in_xfer  = in_valid && !in_stall;
    assign commit   = ex_valid_reg && ex_adv;

    // ------------------------------------------------------------------
    // Architectural state in flops
    // ------------------------------------------------------------------
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [SP_W-1:0] sp_reg, sp_next;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    c8x_rf_wr_t       rf_wr;
    c8x_stk_wr_t      stk_wr;
    logic [REG_W-1:0] vx, vy;
    logic [PC_W-1:0]  stk_top;
    logic [SP_W-1:0]  stk_rd_sp;

    // Read the stack entry below the pointer as it stands after this
    // cycle's retire; a push at that address is forwarded by the stack.
    assign stk_rd_sp = sp_next - SP_ONE;

    c8x_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_xfer),
        .rd_addr_x (instruction[11:8]),
        .rd_addr_y (instruction[7:4]),
        .wr        (rf_wr),
        .rd_data_x (vx),
        .rd_data_y (vy)
    );

    c8x_stack u_stack (
        .clk     (clk),
        .rd_en   (in_xfer),
        .rd_addr (stk_rd_sp[SA_W-1:0]),
        .wr      (stk_wr),
        .rd_data (stk_top)
    );

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    logic [3:0]       grp;
    logic [IDX_W-1:0] xi;
    logic [3:0]       nib;
    logic [7:0]       kk;
    logic [PC_W-1:0]  nnn;
    logic [PC_W-1:0]  pc_inc, pc_inc2;
    logic [REG_W:0]   sum;

    c8x_status_t      ex_status;
    logic             ex_clr, ex_skip, ex_wrote, ex_carry;
    logic [PC_W-1:0]  ex_pc;
    logic [SP_W-1:0]  ex_sp;
    logic             ex_push;

    assign grp     = ex_instr_reg[15:12];
    assign xi      = ex_instr_reg[11:8];
    assign nib     = ex_instr_reg[3:0];
    assign kk      = ex_instr_reg[7:0];
    assign nnn     = ex_instr_reg[11:0];
    assign pc_inc  = pc_reg + PC_STEP;
    assign pc_inc2 = pc_reg + PC_W'(4);
    assign sum     = {1'b0, vx} + {1'b0, vy};

    always_comb
    begin
        ex_status = ST_OK;
        ex_clr    = 1'b0;
        ex_skip   = 1'b0;
        ex_wrote  = 1'b0;
        ex_carry  = 1'b0;
        ex_pc     = pc_inc;
        ex_sp     = sp_reg;
        ex_push   = 1'b0;

        unique case (grp)
            GRP_SYS:
            begin
                if (ex_instr_reg == OP_CLS)
                begin
                    ex_clr = 1'b1;
                end
                else if (ex_instr_reg == OP_RET)
                begin
                    if (sp_reg == '0)
                    begin
                        ex_status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ex_sp = sp_reg - SP_ONE;
                        ex_pc = stk_top;
                    end
                end
                else
                begin
                    ex_status = ST_UNSUPPORTED;
                end
            end
            GRP_JUMP:
            begin
                ex_pc = nnn;
            end
            GRP_CALL:
            begin
                if (sp_reg == SP_FULL)
                begin
                    ex_status = ST_OVERFLOW;
                end
                else
                begin
                    ex_push = 1'b1;
                    ex_sp   = sp_reg + SP_ONE;
                    ex_pc   = nnn;
                end
            end
            GRP_SE_IMM:
            begin
                ex_skip = (vx == kk);
            end
            GRP_SE_REG:
            begin
                if (nib != SE_REG_N)
                    ex_status = ST_UNSUPPORTED;
                else
                    ex_skip = (vx == vy);
            end
            GRP_ALU:
            begin
                if (nib != ALU_ADD)
                begin
                    ex_status = ST_UNSUPPORTED;
                end
                else
                begin
                    ex_wrote = 1'b1;
                    ex_carry = sum[REG_W];
                end
            end
            default:
            begin
                ex_status = ST_UNSUPPORTED;
            end
        endcase

        // a taken skip steps over the next word
        if (ex_skip)
        begin
            ex_pc = pc_inc2;
        end
    end

    // Write ports: sum goes to VX; VF takes the carry unless X is VF, where
    // the sum wins.
    always_comb
    begin
        rf_wr.en     = commit && ex_wrote && (xi != FLAG_IDX);
        rf_wr.idx    = xi;
        rf_wr.val    = sum[REG_W-1:0];
        rf_wr.vf_en  = commit && ex_wrote;
        rf_wr.vf_val = (xi == FLAG_IDX) ? sum[REG_W-1:0] : {{(REG_W-1){1'b0}}, ex_carry};

        stk_wr.en    = commit && ex_push;
        stk_wr.addr  = sp_reg[SA_W-1:0];
        stk_wr.data  = pc_inc;
    end

    assign sp_next = commit ? ex_sp : sp_reg;

    always_comb
    begin
        priority if (cfg_write_en)
            pc_next = cfg_write_data;
        else if (commit)
            pc_next = ex_pc;
        else
            pc_next = pc_reg;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_RESET;
            sp_reg        <= '0;
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            sp_reg <= sp_next;
            // advance the execute stage when it is empty or retiring
            if (!ex_valid_reg || ex_adv)
            begin
                ex_valid_reg <= in_xfer;
            end
            if (ex_adv)
            begin
                out_valid_reg <= ex_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    logic [PC_W-1:0]  next_pc_reg;
    c8x_status_t      status_reg;
    logic             clear_display_reg, skipped_reg, wrote_register_reg, carry_reg;
    logic [IDX_W-1:0] write_index_reg;
    logic [REG_W-1:0] write_value_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ex_instr_reg <= instruction;
        end
        if (commit)
        begin
            next_pc_reg        <= ex_pc;
            status_reg         <= ex_status;
            clear_display_reg  <= ex_clr;
            skipped_reg        <= ex_skip;
            wrote_register_reg <= ex_wrote;
            write_index_reg    <= ex_wrote ? xi : '0;
            write_value_reg    <= ex_wrote ? sum[REG_W-1:0] : '0;
            carry_reg          <= ex_carry;
        end
    end

    assign out_valid      = out_valid_reg;
    assign next_pc        = next_pc_reg;
    assign status         = status_reg;
    assign clear_display  = clear_display_reg;
    assign skipped        = skipped_reg;
    assign wrote_register = wrote_register_reg;
    assign write_index    = write_index_reg;
    assign write_value    = write_value_reg;
    assign carry          = carry_reg;

endmodule

FILE: rtl/c8x_regfile.sv
// ----------------------------------------------------------------------------
// c8x_regfile: general register file V0..VF
// Two synchronous read ports and one write port over V0..VE, with VF in a
// flop of its own. Same-edge writes are forwarded to the read data.
// ----------------------------------------------------------------------------
module c8x_regfile (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [c8x_pkg::IDX_W-1:0] rd_addr_x,
    input  logic [c8x_pkg::IDX_W-1:0] rd_addr_y,
    input  c8x_pkg::c8x_rf_wr_t      wr,
    output logic [c8x_pkg::REG_W-1:0] rd_data_x,
    output logic [c8x_pkg::REG_W-1:0] rd_data_y
);
    import c8x_pkg::*;

    logic [REG_W-1:0]    mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [REG_W-1:0]    vf_reg;

    logic [REG_W-1:0] raw_x_reg, raw_y_reg;
    logic [IDX_W-1:0] addr_x_reg, addr_y_reg;
    logic             fwd_x_reg, fwd_y_reg;
    logic [REG_W-1:0] fwd_val_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            vf_reg  <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.idx] <= 1'b1;
            end
            if (wr.vf_en)
            begin
                vf_reg <= wr.vf_val;
            end
        end
    end

    // read ports; capture a same-edge write for forwarding
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            raw_x_reg   <= vld_reg[rd_addr_x] ? mem[rd_addr_x] : '0;
            raw_y_reg   <= vld_reg[rd_addr_y] ? mem[rd_addr_y] : '0;
            addr_x_reg  <= rd_addr_x;
            addr_y_reg  <= rd_addr_y;
            fwd_x_reg   <= wr.en && (wr.idx == rd_addr_x);
            fwd_y_reg   <= wr.en && (wr.idx == rd_addr_y);
            fwd_val_reg <= wr.val;
        end
    end

    always_comb
    begin
        if (addr_x_reg == FLAG_IDX)
            rd_data_x = vf_reg;
        else if (fwd_x_reg)
            rd_data_x = fwd_val_reg;
        else
            rd_data_x = raw_x_reg;

        if (addr_y_reg == FLAG_IDX)
            rd_data_y = vf_reg;
        else if (fwd_y_reg)
            rd_data_y = fwd_val_reg;
        else
            rd_data_y = raw_y_reg;
    end

endmodule

FILE: rtl/c8x_stack.sv
// ----------------------------------------------------------------------------
// c8x_stack: return address stack memory
// One synchronous read port and one write port; a write to the address read
// at the same edge is forwarded.
// ----------------------------------------------------------------------------
module c8x_stack (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [c8x_pkg::SA_W-1:0] rd_addr,
    input  c8x_pkg::c8x_stk_wr_t     wr,
    output logic [c8x_pkg::PC_W-1:0] rd_data
);
    import c8x_pkg::*;

    logic [PC_W-1:0] mem [STACK_DEPTH];
    logic [PC_W-1:0] raw_reg;
    logic            fwd_reg;
    logic [PC_W-1:0] fwd_val_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            raw_reg     <= mem[rd_addr];
            fwd_reg     <= wr.en && (wr.addr == rd_addr);
            fwd_val_reg <= wr.data;
        end
    end

    assign rd_data = fwd_reg ? fwd_val_reg : raw_reg;

endmodule
